// ===== rtl/mwsp_pkg.sv =====
// ============================================================================
// mwsp_pkg - shared types and constants for the mecanum wheel speed pid
// widths of the fixed-point datapath, register map and the wheel mix
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mwsp_pkg;

    localparam int WHEELS         = 4;
    localparam int ANGLE_BITS_DEF = 13;
    localparam int MOVE_W         = 12;
    localparam int MIX_W          = 14;
    localparam int GAIN_W         = 16;
    localparam int LIMIT_W        = 31;
    localparam int ERR_W          = 32;
    localparam int DERR_W         = 33;
    localparam int MUL_B_W        = 33;
    localparam int PROD_W         = GAIN_W + 1 + MUL_B_W;
    localparam int PROD_SHIFT     = 16;
    localparam int TERM_W         = PROD_W - PROD_SHIFT;
    localparam int PID_W          = TERM_W + 2;
    localparam int DRIVE_W        = 16;
    localparam int DRIVE_MAX      = 32767;
    localparam int DELTA_SHIFT    = 8;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCALE  = 3'd4;

    localparam logic [GAIN_W-1:0]  RST_GAIN_P = 16'd72;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D = 16'd5120;
    localparam logic [LIMIT_W-1:0] RST_LIMIT  = 31'd25600;
    localparam logic [GAIN_W-1:0]  RST_SCALE  = 16'd41;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0] integral_limit;
        logic [GAIN_W-1:0]  setpoint_scale;
    } cfg_t;

    // mecanum mix for one wheel
    function automatic logic signed [MIX_W-1:0] wheel_mix(
        input logic [1:0]               idx,
        input logic signed [MOVE_W-1:0] x,
        input logic signed [MOVE_W-1:0] y,
        input logic signed [MOVE_W-1:0] w
    );
        logic signed [MIX_W-1:0] xe;
        logic signed [MIX_W-1:0] ye;
        logic signed [MIX_W-1:0] we;
        logic signed [MIX_W-1:0] res;
        xe = {{(MIX_W-MOVE_W){x[MOVE_W-1]}}, x};
        ye = {{(MIX_W-MOVE_W){y[MOVE_W-1]}}, y};
        we = {{(MIX_W-MOVE_W){w[MOVE_W-1]}}, w};
        case (idx)
            2'd0:    res = xe - ye - we;
            2'd1:    res = xe + ye - we;
            2'd2:    res = ye - xe - we;
            default: res = -xe - ye - we;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mecanum_wheel_speed_pid.sv =====
// ============================================================================
// mecanum_wheel_speed_pid - four-wheel mecanum speed controller
// per control tick: wheel angle deltas, mecanum setpoints, incremental pid
// and saturating drive accumulators, one lane per wheel
// ============================================================================
// Each request carries four wheel angles and a commanded motion; the four
// wheel lanes run in lockstep, each with one 17x33 multiplier that it uses
// four times in turn (setpoint, then the p, i and d terms). The next request
// is taken once the result has moved into the output register, so a result
// left waiting on the output holds back the next request.
`timescale 1ns / 1ps
`default_nettype none

module mecanum_wheel_speed_pid
#(
    parameter int ANGLE_BITS = mwsp_pkg::ANGLE_BITS_DEF
)
(
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    // apb configuration
    input  wire logic                                         psel,
    input  wire logic                                         penable,
    input  wire logic                                         pwrite,
    input  wire logic [mwsp_pkg::APB_ADDR_W-1:0]              paddr,
    input  wire logic [mwsp_pkg::APB_DATA_W-1:0]              pwdata,
    output logic      [mwsp_pkg::APB_DATA_W-1:0]              prdata,
    output logic                                              pready,
    // request stream
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // angle_0, angle_1, angle_2, angle_3, move_x, move_y, move_w, zero fill
    input  wire logic [((mwsp_pkg::WHEELS * ANGLE_BITS
                         + 3 * mwsp_pkg::MOVE_W + 7) / 8) * 8 - 1:0] s_tdata,
    // result stream
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    // drive_0, drive_1, drive_2, drive_3
    output logic [mwsp_pkg::WHEELS * mwsp_pkg::DRIVE_W - 1:0] m_tdata
);
    import mwsp_pkg::*;

    localparam int IN_W    = WHEELS * ANGLE_BITS + 3 * MOVE_W;
    localparam int OUT_W   = WHEELS * DRIVE_W;
    localparam int MOVE_LO = WHEELS * ANGLE_BITS;

    cfg_t                      cfg;
    logic                      accept;
    logic                      load;
    logic [WHEELS-1:0]         lane_done;
    logic signed [DRIVE_W-1:0] lane_drive [WHEELS];

    logic                      busy_reg, busy_next;
    logic                      pend_reg, pend_next;
    logic                      m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]          m_data_reg, m_data_next;
    logic [IN_W-1:0]           in_reg, in_next;

    mwsp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    genvar g;
    generate
        for (g = 0; g < WHEELS; g++)
        begin : g_lane
            mwsp_lane
            #(
                .ANGLE_BITS (ANGLE_BITS),
                .LANE       (g)
            )
            u_lane
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .start  (accept),
                .cfg    (cfg),
                .angle  (in_reg[g*ANGLE_BITS +: ANGLE_BITS]),
                .move_x ($signed(in_reg[MOVE_LO +: MOVE_W])),
                .move_y ($signed(in_reg[MOVE_LO + MOVE_W +: MOVE_W])),
                .move_w ($signed(in_reg[MOVE_LO + 2*MOVE_W +: MOVE_W])),
                .done   (lane_done[g]),
                .drive  (lane_drive[g])
            );
        end
    endgenerate

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid & s_tready;
    assign load     = pend_reg & (!m_valid_reg | m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // merge the lane drives into the output register
    always_comb
    begin
        m_data_next = m_data_reg;
        if (load)
        begin
            for (int i = 0; i < WHEELS; i++)
            begin
                m_data_next[i*DRIVE_W +: DRIVE_W] = lane_drive[i];
            end
        end
    end

    always_comb
    begin
        in_next      = accept ? s_tdata[IN_W-1:0] : in_reg;
        busy_next    = busy_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (&lane_done)
        begin
            pend_next = 1'b1;
        end
        if (load)
        begin
            pend_next    = 1'b0;
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        m_data_reg <= m_data_next;
    end

    ap_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_done) |-> (&lane_done))
        else $error("wheel lanes finished out of step");

    ap_done_in_request: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_done) |-> (busy_reg && !pend_reg))
        else $error("lane finished with no request in flight");

    ap_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> busy_reg)
        else $error("pending result while block idle");

    ap_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(pend_reg))
        else $error("output raised without a pending result");

endmodule

`default_nettype wire

// ===== rtl/mwsp_regs.sv =====
// ============================================================================
// mwsp_regs - configuration register file
// apb-style write and read access to the gains, integral limit and scale
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mwsp_regs
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mwsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [mwsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [mwsp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output mwsp_pkg::cfg_t                        cfg
);
    import mwsp_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_GAIN_P: cfg_next.gain_p         = pwdata[GAIN_W-1:0];
                REG_GAIN_I: cfg_next.gain_i         = pwdata[GAIN_W-1:0];
                REG_GAIN_D: cfg_next.gain_d         = pwdata[GAIN_W-1:0];
                REG_LIMIT:  cfg_next.integral_limit = pwdata[LIMIT_W-1:0];
                REG_SCALE:  cfg_next.setpoint_scale = pwdata[GAIN_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GAIN_P: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_p};
            REG_GAIN_I: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_i};
            REG_GAIN_D: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_d};
            REG_LIMIT:  prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg_reg.integral_limit};
            REG_SCALE:  prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.setpoint_scale};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= RST_GAIN_P;
            cfg_reg.gain_i         <= RST_GAIN_I;
            cfg_reg.gain_d         <= RST_GAIN_D;
            cfg_reg.integral_limit <= RST_LIMIT;
            cfg_reg.setpoint_scale <= RST_SCALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mwsp_lane.sv =====
// ============================================================================
// mwsp_lane - one wheel's incremental pid
// angle delta with wrap, setpoint, clamped error sum and saturating drive,
// with one multiplier shared over setpoint and the three pid terms
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mwsp_lane
#(
    parameter int ANGLE_BITS = mwsp_pkg::ANGLE_BITS_DEF,
    parameter int LANE       = 0
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire mwsp_pkg::cfg_t                      cfg,
    input  wire logic        [ANGLE_BITS-1:0]        angle,
    input  wire logic signed [mwsp_pkg::MOVE_W-1:0]  move_x,
    input  wire logic signed [mwsp_pkg::MOVE_W-1:0]  move_y,
    input  wire logic signed [mwsp_pkg::MOVE_W-1:0]  move_w,
    output logic                                     done,
    output logic signed      [mwsp_pkg::DRIVE_W-1:0] drive
);
    import mwsp_pkg::*;

    localparam int DW     = ANGLE_BITS + 2;
    localparam int ACC_W  = PID_W + 1;
    localparam int SUM_W  = ERR_W + 1;
    localparam logic signed [DW-1:0]    TURN   = DW'(2 ** ANGLE_BITS);
    localparam logic signed [DW-1:0]    HALF   = DW'(2 ** (ANGLE_BITS - 1));
    localparam logic signed [ACC_W-1:0] DRV_HI = ACC_W'(DRIVE_MAX);
    localparam logic signed [ACC_W-1:0] DRV_LO = -ACC_W'(DRIVE_MAX);
    localparam logic [1:0]              LANE_ID = 2'(LANE);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SETP = 3'd1;
    localparam logic [2:0] ST_ERR  = 3'd2;
    localparam logic [2:0] ST_MP   = 3'd3;
    localparam logic [2:0] ST_MI   = 3'd4;
    localparam logic [2:0] ST_MD   = 3'd5;
    localparam logic [2:0] ST_SUM  = 3'd6;
    localparam logic [2:0] ST_DRV  = 3'd7;

    logic [2:0]                 step_reg, step_next;
    logic [ANGLE_BITS-1:0]      prior_angle_reg, prior_angle_next;
    logic signed [ERR_W-1:0]    prior_error_reg, prior_error_next;
    logic signed [ERR_W-1:0]    error_sum_reg, error_sum_next;
    logic signed [DRIVE_W-1:0]  drive_reg, drive_next;
    logic signed [DW-1:0]       delta_reg, delta_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic signed [DERR_W-1:0]   derr_reg, derr_next;
    logic signed [PID_W-1:0]    pid_reg, pid_next;

    logic signed [MIX_W-1:0]    mix;
    logic signed [DW-1:0]       d_raw;
    logic signed [DW-1:0]       d_wrap;
    logic [GAIN_W-1:0]          mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_out;
    logic signed [ERR_W-1:0]    setp;
    logic signed [ERR_W-1:0]    delta_sh;
    logic signed [ERR_W-1:0]    err_c;
    logic signed [SUM_W-1:0]    sum_raw;
    logic signed [SUM_W-1:0]    lim_pos;
    logic signed [SUM_W-1:0]    sum_c;
    logic signed [TERM_W-1:0]   term;
    logic signed [PID_W-1:0]    term_ext;
    logic signed [ACC_W-1:0]    drv_sum;
    logic signed [ACC_W-1:0]    drv_sat;

    assign mix  = wheel_mix(LANE_ID, move_x, move_y, move_w);
    assign done = (step_reg == ST_DRV);
    assign drive = drive_reg;

    // angle change, wrapped into half a turn either way
    always_comb
    begin
        d_raw = $signed({2'b00, angle}) - $signed({2'b00, prior_angle_reg});
        if (d_raw > HALF)
        begin
            d_wrap = d_raw - TURN;
        end
        else if (d_raw < -HALF)
        begin
            d_wrap = d_raw + TURN;
        end
        else
        begin
            d_wrap = d_raw;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        case (step_reg)
            ST_SETP:
            begin
                mul_a = cfg.setpoint_scale;
                mul_b = {{(MUL_B_W-MIX_W){mix[MIX_W-1]}}, mix};
            end
            ST_MP:
            begin
                mul_a = cfg.gain_p;
                mul_b = {err_reg[ERR_W-1], err_reg};
            end
            ST_MI:
            begin
                mul_a = cfg.gain_i;
                mul_b = {error_sum_reg[ERR_W-1], error_sum_reg};
            end
            ST_MD:
            begin
                mul_a = cfg.gain_d;
                mul_b = derr_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_out = $signed({1'b0, mul_a}) * mul_b;
    end

    // error, derivative and clamped error sum
    always_comb
    begin
        setp     = prod_reg[ERR_W-1:0];
        delta_sh = {{(ERR_W-DW){delta_reg[DW-1]}}, delta_reg} <<< DELTA_SHIFT;
        err_c    = setp - delta_sh;
        lim_pos  = $signed({2'b00, cfg.integral_limit});
        sum_raw  = {error_sum_reg[ERR_W-1], error_sum_reg} + {err_c[ERR_W-1], err_c};
        if (sum_raw > lim_pos)
        begin
            sum_c = lim_pos;
        end
        else if (sum_raw < -lim_pos)
        begin
            sum_c = -lim_pos;
        end
        else
        begin
            sum_c = sum_raw;
        end
    end

    // floor shift of the registered product, then drive saturation
    always_comb
    begin
        term     = prod_reg[PROD_W-1:PROD_SHIFT];
        term_ext = {{(PID_W-TERM_W){term[TERM_W-1]}}, term};
        drv_sum  = {{(ACC_W-DRIVE_W){drive_reg[DRIVE_W-1]}}, drive_reg}
                 + {pid_reg[PID_W-1], pid_reg};
        if (drv_sum > DRV_HI)
        begin
            drv_sat = DRV_HI;
        end
        else if (drv_sum < DRV_LO)
        begin
            drv_sat = DRV_LO;
        end
        else
        begin
            drv_sat = drv_sum;
        end
    end

    always_comb
    begin
        step_next        = step_reg;
        prior_angle_next = prior_angle_reg;
        prior_error_next = prior_error_reg;
        error_sum_next   = error_sum_reg;
        drive_next       = drive_reg;
        delta_next       = delta_reg;
        prod_next        = prod_reg;
        err_next         = err_reg;
        derr_next        = derr_reg;
        pid_next         = pid_reg;
        case (step_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    step_next = ST_SETP;
                end
            end
            ST_SETP:
            begin
                delta_next = d_wrap;
                prod_next  = mul_out;
                step_next  = ST_ERR;
            end
            ST_ERR:
            begin
                err_next         = err_c;
                derr_next        = {err_c[ERR_W-1], err_c}
                                 - {prior_error_reg[ERR_W-1], prior_error_reg};
                prior_error_next = err_c;
                error_sum_next   = sum_c[ERR_W-1:0];
                prior_angle_next = angle;
                step_next        = ST_MP;
            end
            ST_MP:
            begin
                prod_next = mul_out;
                pid_next  = '0;
                step_next = ST_MI;
            end
            ST_MI:
            begin
                prod_next = mul_out;
                pid_next  = pid_reg + term_ext;
                step_next = ST_MD;
            end
            ST_MD:
            begin
                prod_next = mul_out;
                pid_next  = pid_reg + term_ext;
                step_next = ST_SUM;
            end
            ST_SUM:
            begin
                pid_next  = pid_reg + term_ext;
                step_next = ST_DRV;
            end
            ST_DRV:
            begin
                drive_next = drv_sat[DRIVE_W-1:0];
                step_next  = ST_IDLE;
            end
            default:
            begin
                step_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= ST_IDLE;
            prior_angle_reg <= '0;
            prior_error_reg <= '0;
            error_sum_reg   <= '0;
            drive_reg       <= '0;
        end
        else
        begin
            step_reg        <= step_next;
            prior_angle_reg <= prior_angle_next;
            prior_error_reg <= prior_error_next;
            error_sum_reg   <= error_sum_next;
            drive_reg       <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        prod_reg  <= prod_next;
        err_reg   <= err_next;
        derr_reg  <= derr_next;
        pid_reg   <= pid_next;
    end

endmodule

`default_nettype wire
